[design/vcfgc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcfgc_pkg: shared definitions for the genotype column extractor
// Character codes, column numbers, the FORMAT key matcher states and the
// result word passed from the parser to the output register.
// ----------------------------------------------------------------------------
package vcfgc_pkg;

  // Default limit on the number of FORMAT keys and sample subfields tracked.
  localparam int unsigned MAX_FORMAT_KEYS_DEF = 255;

  // Characters of interest in the text stream.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_Q     = 8'h51;

  // Column numbers: CHROM is first, FILTER is the last column whose tab is copied.
  localparam logic [3:0] COL_CHROM  = 4'd0;
  localparam logic [3:0] COL_LAST_TAB_COPY = 4'd6;
  localparam logic [3:0] COL_FORMAT = 4'd8;
  localparam logic [3:0] COL_SAMPLE = 4'd9;

  // Progress of the exact "GQ" match over one FORMAT key.
  typedef enum logic [1:0] {
    KM_START = 2'd0,
    KM_G     = 2'd1,
    KM_GQ    = 2'd2,
    KM_MISS  = 2'd3
  } key_match_e;

  // One processed word: whether it gives a result, and the result byte.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
  } res_t;

endpackage
`default_nettype wire

[design/vcfgc_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcfgc_parser: line and column tracking for the genotype column extractor
// Holds the parse state and, for each word stepped in, updates the state and
// decides whether a byte is emitted and which one.
// ----------------------------------------------------------------------------
module vcfgc_parser #(
  parameter int unsigned MAX_FORMAT_KEYS = vcfgc_pkg::MAX_FORMAT_KEYS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             gq_enable_i,
  output vcfgc_pkg::res_t       res_o
);
  import vcfgc_pkg::*;

  localparam int unsigned SfW = $clog2(MAX_FORMAT_KEYS + 1);
  localparam logic [SfW-1:0] SfMax = SfW'(MAX_FORMAT_KEYS);

  logic           at_line_start_q, at_line_start_d;
  logic           in_header_q, in_header_d;
  logic           chrom_printed_q, chrom_printed_d;
  logic [3:0]     column_q, column_d;
  logic [SfW-1:0] subfield_q, subfield_d;
  logic [SfW-1:0] gq_pos_q, gq_pos_d;
  logic           gq_found_q, gq_found_d;
  key_match_e     key_match_q, key_match_d;

  logic           gq_on;
  logic [SfW-1:0] subfield_inc;
  logic           starts_empty, starts_header, data_path;
  logic           is_tab, is_nl, is_colon;
  logic           key_is_gq;

  // Shared decode of the current word against the current state.
  assign is_tab        = (byte_i == CH_TAB);
  assign is_nl         = (byte_i == CH_NL);
  assign is_colon      = (byte_i == CH_COLON);
  assign gq_on         = gq_enable_i && gq_found_q;
  assign subfield_inc  = (subfield_q == SfMax) ? subfield_q : subfield_q + 1'b1;
  assign starts_empty  = at_line_start_q && is_nl;
  assign starts_header = at_line_start_q && (byte_i == CH_HASH);
  assign data_path     = !starts_empty && !starts_header && !in_header_q;
  // A key that ends now is an accepted GQ match (never the first key).
  assign key_is_gq     = (key_match_q == KM_GQ) && !gq_found_q &&
                         (subfield_q != '0) && (subfield_q != SfMax);

  // Next state.
  always_comb begin
    at_line_start_d = at_line_start_q;
    in_header_d     = in_header_q;
    chrom_printed_d = chrom_printed_q;
    column_d        = column_q;
    subfield_d      = subfield_q;
    gq_pos_d        = gq_pos_q;
    gq_found_d      = gq_found_q;
    key_match_d     = key_match_q;
    if (starts_empty) begin
      at_line_start_d = 1'b1;
    end else if (starts_header) begin
      at_line_start_d = 1'b0;
      in_header_d     = 1'b1;
    end else if (in_header_q) begin
      if (is_nl) begin
        in_header_d     = 1'b0;
        at_line_start_d = 1'b1;
      end
    end else begin
      at_line_start_d = 1'b0;
      if (is_nl) begin
        if (column_q == COL_CHROM) begin
          chrom_printed_d = 1'b1;
        end
        at_line_start_d = 1'b1;
        column_d        = COL_CHROM;
        subfield_d      = '0;
        gq_pos_d        = '0;
        gq_found_d      = 1'b0;
        key_match_d     = KM_START;
      end else if (column_q >= COL_SAMPLE) begin
        if (is_tab) begin
          subfield_d = '0;
        end else if (is_colon) begin
          subfield_d = subfield_inc;
        end
      end else if (column_q == COL_FORMAT) begin
        if (is_tab || is_colon) begin
          if (key_is_gq) begin
            gq_found_d = 1'b1;
            gq_pos_d   = subfield_q;
          end
          subfield_d  = is_tab ? '0 : subfield_inc;
          key_match_d = KM_START;
          if (is_tab) begin
            column_d = COL_SAMPLE;
          end
        end else if (key_match_q == KM_START && byte_i == CH_G) begin
          key_match_d = KM_G;
        end else if (key_match_q == KM_G && byte_i == CH_Q) begin
          key_match_d = KM_GQ;
        end else begin
          key_match_d = KM_MISS;
        end
      end else if (is_tab) begin
        column_d = column_q + 4'd1;
        if (column_q + 4'd1 == COL_FORMAT) begin
          subfield_d  = '0;
          key_match_d = KM_START;
        end
        if (column_q == COL_CHROM) begin
          chrom_printed_d = 1'b1;
        end
      end
    end
  end

  // Result byte for the current word.
  always_comb begin
    res_o.emit = 1'b0;
    res_o.data = byte_i;
    if (data_path) begin
      if (is_nl) begin
        res_o.emit = 1'b1;
      end else if (column_q >= COL_SAMPLE) begin
        if (is_tab) begin
          res_o.emit = 1'b1;
        end else if (is_colon) begin
          res_o.emit = gq_on && (subfield_inc == gq_pos_q);
        end else begin
          res_o.emit = (subfield_q == '0) || (gq_on && (subfield_q == gq_pos_q));
        end
      end else if (column_q == COL_FORMAT) begin
        res_o.emit = is_tab;
      end else if (is_tab) begin
        if (column_q == COL_CHROM) begin
          res_o.emit = !chrom_printed_q;
          res_o.data = CH_NL;
        end else begin
          res_o.emit = (column_q <= COL_LAST_TAB_COPY);
        end
      end else if (column_q == COL_CHROM) begin
        res_o.emit = !chrom_printed_q;
      end else begin
        res_o.emit = 1'b1;
      end
    end
  end

  // Parse state registers, advanced once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      in_header_q     <= 1'b0;
      chrom_printed_q <= 1'b0;
      column_q        <= COL_CHROM;
      subfield_q      <= '0;
      gq_pos_q        <= '0;
      gq_found_q      <= 1'b0;
      key_match_q     <= KM_START;
    end else if (step_i) begin
      at_line_start_q <= at_line_start_d;
      in_header_q     <= in_header_d;
      chrom_printed_q <= chrom_printed_d;
      column_q        <= column_d;
      subfield_q      <= subfield_d;
      gq_pos_q        <= gq_pos_d;
      gq_found_q      <= gq_found_d;
      key_match_q     <= key_match_d;
    end
  end

endmodule
`default_nettype wire

[design/vcf_genotype_column_extractor.sv]
// Path: an accepted input word is held in the input register, then parsed,
// and its output word is captured in the output register unless stalled.
// Throughput: one input word per cycle while the output side is not stalled;
// the parse state updates once per word between the input and output registers.
// Reset: asynchronous, active low; clears the parse state, the GQ mode bit
// and both valid flags, with no further clearing time.
`default_nettype none
// ----------------------------------------------------------------------------
// vcf_genotype_column_extractor: genotype column extractor, top level
// Input register, parser and output register with valid/stall handshakes on
// both sides, and the one-bit GQ mode register.
// ----------------------------------------------------------------------------
module vcf_genotype_column_extractor #(
  parameter int unsigned MAX_FORMAT_KEYS = vcfgc_pkg::MAX_FORMAT_KEYS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [7:0] data_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] out_byte_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i
);
  import vcfgc_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       gq_enable_q;
  logic       advance;
  logic       step;
  res_t       res;

  // The input stage moves on whenever the output register is free or draining.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gq_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      gq_enable_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  // Line parser.
  vcfgc_parser #(
    .MAX_FORMAT_KEYS(MAX_FORMAT_KEYS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .gq_enable_i(gq_enable_q),
    .res_o      (res)
  );

  // Output register.
  assign out_valid_d = advance ? (step && res.emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_byte_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule
`default_nettype wire

[design/vcfgc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcfgc_checker: port checks for the genotype column extractor
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module vcfgc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o
);

  // A stalled output word stays and keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output word dropped or changed while stalled");

  // The input side is only held back by a blocked output word.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output register was free");

  // A fresh output word follows an accepted input word through the input and output registers.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output word without a matching input word");

  // A clock edge with reset applied leaves no output word behind it.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind vcf_genotype_column_extractor vcfgc_checker u_vcfgc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o)
);
`default_nettype wire

[test/tb_vcf_genotype_column_extractor.sv]
// ----------------------------------------------------------------------------
// tb_vcf_genotype_column_extractor: self-checking bench for the extractor
// Feeds variant-call text one byte word at a time, predicts the reduced text
// in a scoreboard and compares every output word in order, across both GQ
// modes and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_vcf_genotype_column_extractor;
  import vcfgc_pkg::*;

  localparam int unsigned MAX_KEYS    = MAX_FORMAT_KEYS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 25;
  localparam int unsigned NUM_PHASES  = 6;
  // GQ mode per random phase, phase 0 in bit 0.
  localparam logic [5:0]  PHASE_GQ    = 6'b011010;
  localparam logic [7:0]  CH_CR       = 8'h0D;

  // Predicts the reduced text and holds the output words still owed.
  class genotype_scoreboard;
    bit          gq_mode;
    bit          line_start;
    bit          header_line;
    bit          chrom_done;
    logic [3:0]  column;
    int unsigned subfield;
    int unsigned gq_index;
    bit          gq_found;
    key_match_e  key_state;
    logic [7:0]  expected_text[$];
    int unsigned mismatches;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned lines_in;

    function new();
      gq_mode     = 1'b0;
      line_start  = 1'b1;
      header_line = 1'b0;
      chrom_done  = 1'b0;
      column      = COL_CHROM;
      subfield    = 0;
      gq_index    = 0;
      gq_found    = 1'b0;
      key_state   = KM_START;
      mismatches  = 0;
      words_in    = 0;
      words_out   = 0;
      lines_in    = 0;
    endfunction

    // Closes one FORMAT key; only an exact GQ past the first key is taken.
    function void close_key();
      if (key_state == KM_GQ && !gq_found && subfield >= 1 && subfield < MAX_KEYS) begin
        gq_found = 1'b1;
        gq_index = subfield;
      end
      if (subfield < MAX_KEYS) subfield++;
      key_state = KM_START;
    endfunction

    // Advances the parse by one character; returns 1 when a word is output.
    function bit reduce_char(input logic [7:0] c, output logic [7:0] o);
      bit         gq_on;
      logic [3:0] prev_col;
      gq_on = gq_mode && gq_found;
      o = c;
      if (line_start) begin
        line_start = 1'b0;
        if (c == CH_NL) begin
          line_start = 1'b1;
          return 1'b0;
        end
        if (c == CH_HASH) begin
          header_line = 1'b1;
          return 1'b0;
        end
      end
      if (header_line) begin
        if (c == CH_NL) begin
          header_line = 1'b0;
          line_start  = 1'b1;
        end
        return 1'b0;
      end
      // A newline ends a data line and clears the per-line state.
      if (c == CH_NL) begin
        if (column == COL_CHROM) chrom_done = 1'b1;
        line_start = 1'b1;
        column     = COL_CHROM;
        subfield   = 0;
        gq_index   = 0;
        gq_found   = 1'b0;
        key_state  = KM_START;
        return 1'b1;
      end
      // Sample columns: genotype always, GQ subfield when enabled and found.
      if (column >= COL_SAMPLE) begin
        if (c == CH_TAB) begin
          subfield = 0;
          return 1'b1;
        end
        if (c == CH_COLON) begin
          if (subfield < MAX_KEYS) subfield++;
          return gq_on && subfield == gq_index;
        end
        return subfield == 0 || (gq_on && subfield == gq_index);
      end
      // FORMAT column: only the closing tab is output, the keys are matched against GQ.
      if (column == COL_FORMAT) begin
        if (c == CH_TAB) begin
          close_key();
          column   = COL_SAMPLE;
          subfield = 0;
          return 1'b1;
        end
        if (c == CH_COLON) close_key();
        else if (key_state == KM_START && c == CH_G) key_state = KM_G;
        else if (key_state == KM_G && c == CH_Q) key_state = KM_GQ;
        else key_state = KM_MISS;
        return 1'b0;
      end
      // Fixed columns: the tab after CHROM ends the chromosome line once.
      if (c == CH_TAB) begin
        prev_col = column;
        column   = column + 4'd1;
        if (column == COL_FORMAT) begin
          subfield  = 0;
          key_state = KM_START;
        end
        if (prev_col == COL_CHROM) begin
          if (!chrom_done) begin
            chrom_done = 1'b1;
            o = CH_NL;
            return 1'b1;
          end
          return 1'b0;
        end
        return prev_col <= COL_LAST_TAB_COPY;
      end
      if (column == COL_CHROM) return !chrom_done;
      return 1'b1;
    endfunction

    function void report(input string what, input logic [7:0] want, input logic [7:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch after %0d output words: %s, expected 0x%02h, got 0x%02h",
                 words_out, what, want, got);
    endfunction

    function void note_input(input logic [7:0] c);
      logic [7:0] o;
      words_in++;
      if (c == CH_NL) lines_in++;
      if (reduce_char(c, o)) expected_text.push_back(o);
    endfunction

    function void check_output(input logic [7:0] got);
      logic [7:0] want;
      words_out++;
      if (expected_text.size() == 0) begin
        report("output word with nothing expected", 8'h00, got);
      end else begin
        want = expected_text.pop_front();
        if (want !== got) report("out_byte differs", want, got);
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;

  genotype_scoreboard sb;
  logic [7:0]  text_q[$];
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned cycle_count        = 0;
  string       key_pool[8] = '{"GT", "GQ", "DP", "G", "Q", "GQX", "AD", "gQ"};
  string       char_pool   = "01AGTCQgq./|_-=";

  vcf_genotype_column_extractor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock, period 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, sb.expected_text.size());
      $display("** vcf_genotype_column_extractor: FAILED **");
      $finish;
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // Both handshakes are observed at the clock edge, before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(data_byte_i);
      if (out_valid_o && !out_stall_i) sb.check_output(out_byte_o);
    end
  end

  // Text building helpers.
  function automatic void add_ch(input logic [7:0] c);
    text_q.push_back(c);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Mostly plain characters, now and then any byte but a tab or a newline.
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(15) == 0) begin
      c = 8'($urandom_range(255));
      if (c == CH_NL || c == CH_TAB) c = CH_CR;
    end else begin
      c = char_pool[$urandom_range(char_pool.len() - 1)];
    end
    return c;
  endfunction

  function automatic void add_token(input int unsigned max_len);
    repeat ($urandom_range(max_len)) add_ch(rand_char());
  endfunction

  // A record cut after last_col, with FORMAT and samples when it reaches them.
  function automatic void add_record(input int unsigned last_col, input int unsigned samples);
    int unsigned nkeys;
    int unsigned pick;
    int unsigned nsub;
    nkeys = $urandom_range(1, 5);
    add_token(3);
    for (int unsigned col = 1; col <= last_col && col < 8; col++) begin
      add_ch(CH_TAB);
      add_token(3);
    end
    if (last_col >= 8) begin
      add_ch(CH_TAB);
      for (int unsigned k = 0; k < nkeys; k++) begin
        if (k != 0) add_ch(CH_COLON);
        pick = $urandom_range(11);
        if (pick < 3) add_str("GQ");
        else if (pick == 10) add_token(3);
        else if (pick < 10) add_str(key_pool[pick - 2]);
      end
      repeat (samples) begin
        add_ch(CH_TAB);
        nsub = $urandom_range(1, nkeys + 1);
        for (int unsigned j = 0; j < nsub; j++) begin
          if (j != 0) add_ch(CH_COLON);
          add_token(j == 0 ? 3 : 2);
        end
      end
    end
    if ($urandom_range(7) == 0) add_ch(CH_CR);
    add_ch(CH_NL);
  endfunction

  // Mostly well-formed records, the rest headers, blanks, cut records, noise.
  function automatic void add_random_line();
    int unsigned r;
    int unsigned c;
    r = $urandom_range(99);
    if (r < 70) begin
      add_record(8, $urandom_range(4));
    end else if (r < 78) begin
      add_ch(CH_HASH);
      add_token(4);
      if ($urandom_range(1)) add_ch(CH_TAB);
      add_token(3);
      add_ch(CH_NL);
    end else if (r < 84) begin
      add_ch(CH_NL);
    end else if (r < 94) begin
      add_record($urandom_range(8), $urandom_range(2));
    end else begin
      repeat ($urandom_range(1, 16)) begin
        c = $urandom_range(7);
        if (c == 0) add_ch(CH_TAB);
        else if (c == 1) add_ch(CH_COLON);
        else if (c == 2) add_ch(CH_HASH);
        else add_ch(8'($urandom_range(255)));
      end
      add_ch(CH_NL);
    end
  endfunction

  // Sends one word, with random idle cycles ahead of it.
  task automatic send_word(input logic [7:0] c);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_text();
    while (text_q.size() != 0) send_word(text_q.pop_front());
    in_valid_i <= 1'b0;
  endtask

  // Waits for every expected word, then for the pipeline to empty.
  task automatic settle();
    while (sb.expected_text.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_gq_mode(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.gq_mode  = v;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed text with the GQ mode on.
    write_gq_mode(1'b1);
    add_str("##fileformat\n");
    // Empty line, then a first data line that ends inside CHROM.
    add_str("\nc1\n#CHROM\tPOS\n");
    // GQ as the first key is skipped; an empty GQ subfield gives a colon alone.
    add_str("c2\t5\tid\tA\tT\t30\tPASS\tDP=3\tGQ:GT:GQ\t1:2:3\t0/1\t4::\n");
    // Hash inside data, a sample without GQ, a carriage return in the GQ value.
    add_str("c3\t#\t\t\t\t\t\t\tGT:DP:GQ\t0|1:7\t1/1:2:9\r\n");
    // Extreme byte values in a cut record.
    add_str("c4\tz");
    add_ch(8'hFF);
    add_ch(8'h80);
    add_ch(8'h00);
    add_ch(8'h7F);
    add_str("\t.\n");
    // A later line ending in CHROM, and a near miss ahead of the real key.
    add_str("c5\n");
    add_str("c6\t1\t.\tA\tC\t.\t.\t.\tGT:GQX:GQ\t0/0:1:5\t./.\n");
    send_text();

    // Random phases across both modes and every idling pattern.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_gq_mode(PHASE_GQ[phase]);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      while (text_q.size() < PHASE_BYTES) add_random_line();
      if (phase == 3) begin
        // GQ beyond the key limit is never matched; sample subfields saturate.
        add_str("L\t1\t.\tA\tC\t.\t.\t.\tGT");
        repeat (254) add_ch(CH_COLON);
        add_str(":GQ:GQ\t0/1");
        repeat (258) add_ch(CH_COLON);
        add_str("x\t1|1:5\n");
      end
      send_text();
    end

    settle();
    $display("Covered %0d input words in %0d lines, %0d output words checked, %0d mismatches,",
             sb.words_in, sb.lines_in, sb.words_out, sb.mismatches);
    $display("with the GQ mode off and on and four sender and receiver idling patterns.");
    if (sb.mismatches == 0 && sb.expected_text.size() == 0) begin
      $display("** vcf_genotype_column_extractor: PASSED **");
    end else begin
      $display("** vcf_genotype_column_extractor: FAILED **");
    end
    $finish;
  end

endmodule
